/* rtl/crosshair_segment_generator_macros.svh */
// ----------------------------------------------------------------------------
// crosshair segment generator assertion macros
// clocked, reset-gated property checks shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef CROSSHAIR_SEGMENT_GENERATOR_MACROS_SVH
`define CROSSHAIR_SEGMENT_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/csg_pkg.sv */
// ----------------------------------------------------------------------------
// csg_pkg
// shared types and constants of the crosshair segment generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int BOARD_BITS     = 16;
  localparam int SHAPE_BITS     = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SEG_BITS       = 3;
  localparam int QUEUE_DEPTH    = 2;

  // q16 slope constants
  localparam logic [16:0] Q_ONE       = 17'd65536;
  localparam logic [16:0] Q_SQRT3     = 17'd113512;
  localparam logic [16:0] Q_INV_SQRT3 = 17'd37837;

  // shape codes
  localparam logic [SHAPE_BITS-1:0] SHAPE_PLAIN      = 2'd0;
  localparam logic [SHAPE_BITS-1:0] SHAPE_UNION_JACK = 2'd1;
  localparam logic [SHAPE_BITS-1:0] SHAPE_DOZEN      = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOARD_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOARD_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSS_SHAPE  = 2'd2;

  // last segment index per shape
  localparam logic [SEG_BITS-1:0] LAST_PLAIN      = 3'd1;
  localparam logic [SEG_BITS-1:0] LAST_UNION_JACK = 3'd3;
  localparam logic [SEG_BITS-1:0] LAST_DOZEN      = 3'd5;

  typedef struct packed {
    logic [BOARD_BITS-1:0] width;
    logic [BOARD_BITS-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [BOARD_BITS-1:0] x;
    logic [BOARD_BITS-1:0] y;
    logic [SEG_BITS-1:0]   last_idx;
    logic                  dozen;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_word_t;

endpackage

`default_nettype wire

/* rtl/csg_front.sv */
// ----------------------------------------------------------------------------
// csg_front
// configuration registers and input word classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [csg_pkg::BOARD_BITS-1:0]      in_cursor_x,
  input  logic [csg_pkg::BOARD_BITS-1:0]      in_cursor_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csg_pkg::BOARD_BITS-1:0]      cfg_data,
  output csg_pkg::cfg_t                       cfg,
  output csg_pkg::q_word_t                    push,
  input  logic                                q_full
);
  import csg_pkg::*;

  logic [BOARD_BITS-1:0] width_r;
  logic [BOARD_BITS-1:0] height_r;
  logic [SHAPE_BITS-1:0] shape_r;
  logic                  cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= {BOARD_BITS{1'b1}};
      height_r <= {BOARD_BITS{1'b1}};
      shape_r  <= SHAPE_PLAIN;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BOARD_WIDTH:  width_r  <= cfg_data;
        REG_BOARD_HEIGHT: height_r <= cfg_data;
        REG_CROSS_SHAPE:  shape_r  <= cfg_data[SHAPE_BITS-1:0];
        default:          ;
      endcase
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign in_stall   = q_full;

  always_comb begin
    push.valid       = in_valid && !q_full;
    push.item.x      = in_cursor_x;
    push.item.y      = in_cursor_y;
    push.item.dozen  = (shape_r == SHAPE_DOZEN);
    unique case (shape_r)
      SHAPE_UNION_JACK: push.item.last_idx = LAST_UNION_JACK;
      SHAPE_DOZEN:      push.item.last_idx = LAST_DOZEN;
      default:          push.item.last_idx = LAST_PLAIN;  // unused code gives plain cross
    endcase
  end

endmodule

`default_nettype wire

/* rtl/csg_queue.sv */
// ----------------------------------------------------------------------------
// csg_queue
// short fifo of classified cursor words between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "crosshair_segment_generator_macros.svh"

module csg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  csg_pkg::q_word_t  push,
  output logic              q_full,
  output csg_pkg::q_word_t  head,
  input  logic              pop
);
  import csg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign q_full     = (count_r == DEPTH_CNT);
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  `CSG_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= DEPTH_CNT, "queue count past depth")
  `CSG_ASSERT_IMPL(a_no_pop_empty, pop, count_r != '0, "pop from empty queue")
  `CSG_ASSERT_NEXT(a_push_counts, push.valid && !pop, count_r == $past(count_r) + 1'b1,
                   "push lost in queue count")

endmodule

`default_nettype wire

/* rtl/csg_back.sv */
// ----------------------------------------------------------------------------
// csg_back
// segment sequencer with a multiply stage and a clamp stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "crosshair_segment_generator_macros.svh"

module csg_back #(
  parameter int COORD_BITS = csg_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csg_pkg::cfg_t          cfg,
  input  csg_pkg::q_word_t       head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_BITS-1:0]  out_start_x,
  output logic [COORD_BITS-1:0]  out_start_y,
  output logic [COORD_BITS-1:0]  out_end_x,
  output logic [COORD_BITS-1:0]  out_end_y,
  output logic                   out_last_segment
);
  import csg_pkg::*;

  localparam logic [1:0] KIND_VERT = 2'd0;
  localparam logic [1:0] KIND_HORZ = 2'd1;
  localparam logic [1:0] KIND_DIAG = 2'd2;

  // floor(prod / 65536) added to base, clamped to 0..hi
  function automatic logic [BOARD_BITS-1:0] diag_coord(input logic [BOARD_BITS-1:0] base,
                                                       input logic signed [34:0] prod,
                                                       input logic [BOARD_BITS-1:0] hi);
    logic signed [19:0] term;
    logic signed [19:0] sum;
    logic signed [19:0] lim;
    term = {prod[34], prod[34:16]};
    sum  = $signed({4'b0000, base}) + term;
    lim  = $signed({4'b0000, hi});
    priority if (sum > lim) begin
      return hi;
    end else if (sum < 20'sd0) begin
      return '0;
    end else begin
      return sum[BOARD_BITS-1:0];
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] to_coord(input logic [BOARD_BITS-1:0] v);
    logic [COORD_BITS+BOARD_BITS-1:0] ext;
    ext = {{COORD_BITS{1'b0}}, v};
    return ext[COORD_BITS-1:0];
  endfunction

  // sequencer
  logic [SEG_BITS-1:0] seg_r, seg_nxt;
  logic                seg_last, issue, out_free, s1_free;
  logic [1:0]          kind;
  logic                flip;
  logic [16:0]         kx, ky;
  logic signed [16:0]  dx0, dx1, dy0, dy1;
  logic signed [16:0]  xs, ys, ws, hs;

  // multiply stage
  logic                     s1_valid_r;
  logic [1:0]               s1_kind_r;
  logic                     s1_last_r;
  logic [BOARD_BITS-1:0]    s1_x_r, s1_y_r;
  logic signed [34:0]       s1_px0_r, s1_px1_r, s1_py0_r, s1_py1_r;

  // output stage
  logic                     out_valid_r;
  logic [COORD_BITS-1:0]    out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                     out_last_r;
  logic [BOARD_BITS-1:0]    sx, sy, ex, ey;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign seg_last = (seg_r == head.item.last_idx);
  assign issue    = head.valid && s1_free;
  assign pop      = issue && seg_last;

  always_comb begin
    seg_nxt = seg_r;
    if (issue) begin
      seg_nxt = seg_last ? '0 : seg_r + 1'b1;
    end
  end

  always_comb begin
    unique case (seg_r)
      3'd0:    kind = KIND_VERT;
      3'd1:    kind = KIND_HORZ;
      default: kind = KIND_DIAG;
    endcase
    flip = head.item.dozen ? (seg_r >= 3'd4) : (seg_r == 3'd3);
    priority if (!head.item.dozen) begin
      kx = Q_ONE;
      ky = Q_ONE;
    end else if (!seg_r[0]) begin
      kx = Q_INV_SQRT3;
      ky = Q_SQRT3;
    end else begin
      kx = Q_SQRT3;
      ky = Q_INV_SQRT3;
    end
    xs = $signed({1'b0, head.item.x});
    ys = $signed({1'b0, head.item.y});
    ws = $signed({1'b0, cfg.width});
    hs = $signed({1'b0, cfg.height});
    if (!flip) begin
      dx0 = hs - ys;
      dx1 = 17'sd0 - ys;
      dy0 = ws - xs;
      dy1 = 17'sd0 - xs;
    end else begin
      dx0 = ys - hs;
      dx1 = ys;
      dy0 = xs;
      dy1 = xs - ws;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      if (s1_free) begin
        s1_valid_r <= issue;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= kind;
      s1_last_r <= seg_last;
      s1_x_r    <= head.item.x;
      s1_y_r    <= head.item.y;
      s1_px0_r  <= dx0 * $signed({1'b0, kx});
      s1_px1_r  <= dx1 * $signed({1'b0, kx});
      s1_py0_r  <= dy0 * $signed({1'b0, ky});
      s1_py1_r  <= dy1 * $signed({1'b0, ky});
    end
  end

  always_comb begin
    unique case (s1_kind_r)
      KIND_VERT: begin
        sx = s1_x_r;
        sy = '0;
        ex = s1_x_r;
        ey = cfg.height;
      end
      KIND_HORZ: begin
        sx = '0;
        sy = s1_y_r;
        ex = cfg.width;
        ey = s1_y_r;
      end
      default: begin
        sx = diag_coord(s1_x_r, s1_px0_r, cfg.width);
        sy = diag_coord(s1_y_r, s1_py0_r, cfg.height);
        ex = diag_coord(s1_x_r, s1_px1_r, cfg.width);
        ey = diag_coord(s1_y_r, s1_py1_r, cfg.height);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_sx_r   <= to_coord(sx);
      out_sy_r   <= to_coord(sy);
      out_ex_r   <= to_coord(ex);
      out_ey_r   <= to_coord(ey);
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_start_x      = out_sx_r;
  assign out_start_y      = out_sy_r;
  assign out_end_x        = out_ex_r;
  assign out_end_y        = out_ey_r;
  assign out_last_segment = out_last_r;

  `CSG_ASSERT_NEXT(a_seg_wrap, issue && seg_last, seg_r == '0, "segment index did not wrap")
  `CSG_ASSERT_IMPL(a_seg_range, head.valid, seg_r <= head.item.last_idx,
                   "segment index past last segment")
  `CSG_ASSERT_NEXT(a_stage_moves, s1_valid_r && out_free, out_valid_r,
                   "multiply stage word dropped")

endmodule

`default_nettype wire

/* rtl/crosshair_segment_generator.sv */
// ----------------------------------------------------------------------------
// crosshair_segment_generator
// cursor position in, crosshair line segments out, one segment per word
// ----------------------------------------------------------------------------
// For each accepted cursor word the block emits 2, 4 or 6 segment words
// (plain cross, 45-degree lines, or 30/60-degree lines, set by cross_shape),
// one segment per clock when the output is not stalled; the back end's
// segment sequencer issues one segment a cycle, while the pipe can take it,
// into a two-stage multiply and clamp pipe. The first segment passes through
// the queue, the multiply stage and the output register before it leaves.
// A two-word queue sits between the front end and the back end, so new
// cursor words are taken while earlier segments are still going out.
// Configuration writes are always ready and take effect at once; write them
// only while no segments are pending. The vertical and horizontal lines are
// not clamped, the diagonal endpoints are clamped to the board.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crosshair_segment_generator #(
  parameter int COORD_BITS = csg_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // cursor words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [csg_pkg::BOARD_BITS-1:0]      in_cursor_x,
  input  logic [csg_pkg::BOARD_BITS-1:0]      in_cursor_y,
  // segment words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [COORD_BITS-1:0]               out_start_x,
  output logic [COORD_BITS-1:0]               out_start_y,
  output logic [COORD_BITS-1:0]               out_end_x,
  output logic [COORD_BITS-1:0]               out_end_y,
  output logic                                out_last_segment,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csg_pkg::BOARD_BITS-1:0]      cfg_data
);
  import csg_pkg::*;

  cfg_t    cfg;      // live board size
  q_word_t push;     // classified cursor word into the queue
  q_word_t head;     // oldest queued word
  logic    q_full;
  logic    pop;

  // front end: registers, accept and classify by shape
  csg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cursor_x (in_cursor_x),
    .in_cursor_y (in_cursor_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .push        (push),
    .q_full      (q_full)
  );

  // decoupling queue
  csg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // back end: segment sequencer, slope multiply, clamp, output register
  csg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_x      (out_start_x),
    .out_start_y      (out_start_y),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_last_segment (out_last_segment)
  );

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crosshair segment generator testbench
// cursor words go in through a queue-fed driver, and a clocked monitor checks
// every segment word against an in-bench crosshair predictor. The run covers
// all shapes, board sizes from zero to full, random idling on both sides and
// one long output hold-off.
// ----------------------------------------------------------------------------

module tb;
  import csg_pkg::*;

  localparam int COORD_W     = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER  = 60;    // cursor words accepted before the long hold

  typedef struct {
    bit [BOARD_BITS-1:0] x;
    bit [BOARD_BITS-1:0] y;
  } cursor_t;

  typedef struct {
    bit [COORD_W-1:0] start_x;
    bit [COORD_W-1:0] start_y;
    bit [COORD_W-1:0] end_x;
    bit [COORD_W-1:0] end_y;
    bit               last_segment;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [BOARD_BITS-1:0]     in_cursor_x = '0;
  logic [BOARD_BITS-1:0]     in_cursor_y = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COORD_W-1:0]        out_start_x;
  logic [COORD_W-1:0]        out_start_y;
  logic [COORD_W-1:0]        out_end_x;
  logic [COORD_W-1:0]        out_end_y;
  logic                      out_last_segment;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [BOARD_BITS-1:0]     cfg_data = '0;

  // bench copy of the registers, matches reset values of the block
  bit [BOARD_BITS-1:0] board_w = 16'hFFFF;
  bit [BOARD_BITS-1:0] board_h = 16'hFFFF;
  bit [SHAPE_BITS-1:0] shape_sel = SHAPE_PLAIN;

  cursor_t  cursor_queue[$];      // cursor words waiting for the driver
  segment_t pending_segments[$];  // predicted segment words, oldest first

  int send_idle_pct = 11;
  int recv_idle_pct = 54;
  int error_count = 0;
  int words_accepted = 0;
  int segments_checked = 0;
  int shape_words[4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  crosshair_segment_generator #(.COORD_BITS(COORD_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cursor_x      (in_cursor_x),
    .in_cursor_y      (in_cursor_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_x      (out_start_x),
    .out_start_y      (out_start_y),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_last_segment (out_last_segment),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report(input string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  // q16 slope product, rounded toward minus infinity
  function automatic longint q16_floor(longint d, longint k);
    return (d * k) >>> 16;
  endfunction

  function automatic bit [COORD_W-1:0] pin_to_board(longint v, longint hi);
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return v[COORD_W-1:0];
  endfunction

  // one diagonal through the cursor; kx scales x offsets, ky the y offsets,
  // mirrored selects the line running the other way
  function automatic segment_t diagonal_segment(longint x, longint y, longint kx,
                                                longint ky, bit mirrored);
    longint   w, h, x0, x1, y0, y1;
    segment_t s;
    w = board_w;
    h = board_h;
    if (!mirrored) begin
      x0 = x + q16_floor(h - y, kx);
      x1 = x + q16_floor(-y, kx);
      y0 = y + q16_floor(w - x, ky);
      y1 = y + q16_floor(-x, ky);
    end else begin
      x0 = x + q16_floor(y - h, kx);
      x1 = x + q16_floor(y, kx);
      y0 = y + q16_floor(x, ky);
      y1 = y + q16_floor(x - w, ky);
    end
    s.start_x = pin_to_board(x0, w);
    s.start_y = pin_to_board(y0, h);
    s.end_x = pin_to_board(x1, w);
    s.end_y = pin_to_board(y1, h);
    s.last_segment = 1'b0;
    return s;
  endfunction

  // queue up every segment word that one cursor word produces
  function automatic void plan_crosshair(bit [BOARD_BITS-1:0] cx, bit [BOARD_BITS-1:0] cy);
    segment_t segs[6];
    int       n;
    longint   x, y, k1, ks, ki;
    x = cx;
    y = cy;
    k1 = Q_ONE;
    ks = Q_SQRT3;
    ki = Q_INV_SQRT3;
    // plain cross, never clamped
    segs[0] = '{cx, '0, cx, board_h, 1'b0};
    segs[1] = '{'0, cy, board_w, cy, 1'b0};
    n = 2;
    if (shape_sel == SHAPE_UNION_JACK) begin
      segs[2] = diagonal_segment(x, y, k1, k1, 1'b0);
      segs[3] = diagonal_segment(x, y, k1, k1, 1'b1);
      n = 4;
    end else if (shape_sel == SHAPE_DOZEN) begin
      segs[2] = diagonal_segment(x, y, ki, ks, 1'b0);
      segs[3] = diagonal_segment(x, y, ks, ki, 1'b0);
      segs[4] = diagonal_segment(x, y, ki, ks, 1'b1);
      segs[5] = diagonal_segment(x, y, ks, ki, 1'b1);
      n = 6;
    end
    segs[n-1].last_segment = 1'b1;
    for (int i = 0; i < n; i++) begin
      pending_segments.push_back(segs[i]);
    end
    shape_words[shape_sel]++;
  endfunction

  // ------------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_crosshair(in_cursor_x, in_cursor_y);
        words_accepted++;
      end
      // payload only moves when nothing is offered or the word just went in
      if (!in_valid || !in_stall) begin
        if (cursor_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cursor_t c;
          c = cursor_queue.pop_front();
          in_valid <= 1'b1;
          in_cursor_x <= c.x;
          in_cursor_y <= c.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------- receiver stalling

  // one long hold-off once traffic is flowing, so the front queue fills and
  // the block pushes back on the cursor side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && words_accepted >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_segments.size() == 0) begin
        report($sformatf("segment word (%0d,%0d)-(%0d,%0d) last %0b with none pending",
                         out_start_x, out_start_y, out_end_x, out_end_y,
                         out_last_segment));
      end else begin
        segment_t want;
        want = pending_segments.pop_front();
        if (out_start_x !== want.start_x || out_start_y !== want.start_y ||
            out_end_x !== want.end_x || out_end_y !== want.end_y ||
            out_last_segment !== want.last_segment) begin
          report($sformatf("segment %0d: got (%0d,%0d)-(%0d,%0d) last %0b, want (%0d,%0d)-(%0d,%0d) last %0b",
                           segments_checked, out_start_x, out_start_y, out_end_x,
                           out_end_y, out_last_segment, want.start_x, want.start_y,
                           want.end_x, want.end_y, want.last_segment));
        end
        segments_checked++;
      end
    end
  end

  // ------------------------------------------------------------------ timeout

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segment words still pending",
               cycle_count, pending_segments.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ----------------------------------------------------------------- sequence

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [BOARD_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BOARD_WIDTH:  board_w = data;
      REG_BOARD_HEIGHT: board_h = data;
      REG_CROSS_SHAPE:  shape_sel = data[SHAPE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_board(input bit [BOARD_BITS-1:0] w, input bit [BOARD_BITS-1:0] h,
                           input bit [SHAPE_BITS-1:0] shp);
    write_reg(REG_BOARD_WIDTH, w);
    write_reg(REG_BOARD_HEIGHT, h);
    write_reg(REG_CROSS_SHAPE, {{(BOARD_BITS-SHAPE_BITS){1'b0}}, shp});
  endtask

  task automatic add_cursor(input bit [BOARD_BITS-1:0] x, input bit [BOARD_BITS-1:0] y);
    cursor_queue.push_back('{x, y});
  endtask

  // everything sent and checked, then a few cycles for the pipe to settle
  task automatic wait_drained();
    while (cursor_queue.size() != 0 || in_valid || pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  initial begin
    bit [BOARD_BITS-1:0] rx, ry;
    bit [SHAPE_BITS-1:0] rshape;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners under reset config (full board, plain cross)
    add_cursor(16'd0, 16'd0);
    add_cursor(16'hFFFF, 16'hFFFF);
    add_cursor(16'd0, 16'hFFFF);
    wait_drained();

    // 45-degree lines on the full board
    write_reg(REG_CROSS_SHAPE, {{(BOARD_BITS-SHAPE_BITS){1'b0}}, SHAPE_UNION_JACK});
    add_cursor(16'd32768, 16'd16384);
    add_cursor(16'd0, 16'hFFFF);
    add_cursor(16'hFFFF, 16'd0);
    wait_drained();

    // 30/60-degree lines, slopes truncate toward minus infinity
    write_reg(REG_CROSS_SHAPE, {{(BOARD_BITS-SHAPE_BITS){1'b0}}, SHAPE_DOZEN});
    add_cursor(16'd0, 16'd0);
    add_cursor(16'hFFFF, 16'hFFFF);
    add_cursor(16'd40000, 16'd1234);
    add_cursor(16'd100, 16'd60000);
    wait_drained();

    // unused shape code falls back to the plain cross
    write_reg(REG_CROSS_SHAPE, 16'd3);
    add_cursor(16'd500, 16'd700);
    wait_drained();

    // small board, cursor inside and off the board
    set_board(16'd100, 16'd50, SHAPE_DOZEN);
    add_cursor(16'd200, 16'd300);
    add_cursor(16'd50, 16'd25);
    add_cursor(16'd0, 16'd0);
    wait_drained();
    write_reg(REG_CROSS_SHAPE, {{(BOARD_BITS-SHAPE_BITS){1'b0}}, SHAPE_UNION_JACK});
    add_cursor(16'hFFFF, 16'hFFFF);
    add_cursor(16'd10, 16'd40);
    wait_drained();

    // zero-size board pins every diagonal endpoint to the origin
    set_board(16'd0, 16'd0, SHAPE_DOZEN);
    add_cursor(16'd0, 16'd0);
    add_cursor(16'd7, 16'd9);
    wait_drained();

    // random part: nine blocks, idling pattern changes every three blocks
    for (int blk = 0; blk < 9; blk++) begin
      case (blk / 3)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (blk)
        0: set_board(16'hFFFF, 16'hFFFF, SHAPE_DOZEN);
        1: set_board(16'd1, 16'd1, SHAPE_UNION_JACK);
        2: set_board(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)), SHAPE_DOZEN);
        default: begin
          rshape = 2'($urandom_range(0, 3));
          if ($urandom_range(0, 1)) begin
            set_board(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), rshape);
          end else begin
            set_board(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)), rshape);
          end
        end
      endcase
      for (int i = 0; i < 22; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            rx = 16'($urandom);
            ry = 16'($urandom);
          end
          1: begin
            rx = 16'($urandom_range(0, board_w));
            ry = 16'($urandom_range(0, board_h));
          end
          2: begin
            // board edges and coordinate extremes
            rx = $urandom_range(0, 1) ? board_w : ($urandom_range(0, 1) ? 16'hFFFF : 16'd0);
            ry = $urandom_range(0, 1) ? board_h : ($urandom_range(0, 1) ? 16'hFFFF : 16'd0);
          end
          default: begin
            // around the board and past it
            rx = 16'($urandom_range(0, (board_w > 16'd32767) ? 65535 : 2 * board_w + 1));
            ry = 16'($urandom_range(0, (board_h > 16'd32767) ? 65535 : 2 * board_h + 1));
          end
        endcase
        add_cursor(rx, ry);
      end
      wait_drained();
    end

    $display("checked %0d segment words from %0d cursor words", segments_checked,
             words_accepted);
    $display("cursor words per shape: plain %0d, 45-degree %0d, 30/60-degree %0d, unused %0d",
             shape_words[0], shape_words[1], shape_words[2], shape_words[3]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* crosshair_segment_generator.f */
+incdir+rtl
rtl/csg_pkg.sv
rtl/csg_front.sv
rtl/csg_queue.sv
rtl/csg_back.sv
rtl/crosshair_segment_generator.sv
verif/tb.sv
